[src/lppt_pkg.sv]
package lppt_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 5;

  localparam logic [1:0] OP_OPEN   = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] REG_WORLD  = 2'd0;
  localparam logic [1:0] REG_LINE   = 2'd1;
  localparam logic [1:0] REG_SERVER = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] proc_first;
    logic [KEY_W-1:0] proc_second;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

[src/linear_probe_pair_table.sv]
// Channel   | Signals                              | Transfer
// ----------+--------------------------------------+------------------------------------
// command   | start, busy, cmd                     | edge with start high and busy low
// result    | done, result                         | one cycle with done high, no stall
// config    | psel, penable, pwrite, paddr, pwdata | setup then access, pready tied high
//
// After reset the table is cleared, one slot a cycle, over all DEPTH slots (24 by
// default) with busy high. A command whose fields mismatch, or an unused opcode, gives
// its result in the next cycle. Otherwise the key is reduced modulo DEPTH and the
// table (one read port, one write port) is probed one slot a cycle, up to all DEPTH
// slots. busy falls in the cycle that done is high.
module linear_probe_pair_table #(
  parameter int MAX_SERVERS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lppt_pkg::cmd_t      cmd,
  output logic                done,
  output lppt_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lppt_pkg::*;

  localparam int DEPTH  = MAX_SERVERS * ((MAX_SERVERS - 1) >> 1);
  localparam int IW     = $clog2(DEPTH);
  localparam int WORD_W = KEY_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  state_t            state;
  logic [31:0]       world_mask;
  logic [31:0]       line_mask;
  logic [31:0]       server_mask;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic [IW-1:0]     p_idx;
  logic [IW-1:0]     q_idx;
  logic              q_vld;
  logic [IW-1:0]     ev_cnt;
  logic [KEY_W-1:0]  key;
  logic [1:0]        op;

  logic              accept;
  logic              cfg_write;
  logic              probe_op;
  logic              mismatch;
  logic [KEY_W-1:0]  cmd_key;
  logic              hash_last;
  logic [IW-1:0]     hash_rem;
  logic [IW-1:0]     p_idx_next;
  logic              eval;
  logic              e_valid;
  logic              e_eq;
  logic              e_stop;
  logic              e_miss;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  result_t           e_res;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_WORLD:  prdata = world_mask;
      REG_LINE:   prdata = line_mask;
      REG_SERVER: prdata = server_mask;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      world_mask  <= '0;
      line_mask   <= '0;
      server_mask <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WORLD:  world_mask  <= pwdata;
        REG_LINE:   line_mask   <= pwdata;
        REG_SERVER: server_mask <= pwdata;
        default:    ;
      endcase
    end
  end

  assign cmd_key  = (cmd.proc_first & server_mask) | (cmd.proc_second & server_mask);
  assign probe_op = (cmd.opcode inside {OP_OPEN, OP_CLOSE, OP_LOOKUP});

  always_comb begin
    mismatch = ((cmd.proc_first & line_mask) != (cmd.proc_second & line_mask));
    if (cmd.opcode != OP_OPEN) begin
      mismatch = mismatch ||
                 ((cmd.proc_first & world_mask) != (cmd.proc_second & world_mask));
    end
  end

  lppt_hash #(
    .DEPTH (DEPTH)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .go   (accept && probe_op && !mismatch),
    .key  (cmd_key),
    .last (hash_last),
    .rem  (hash_rem)
  );

  assign p_idx_next = (p_idx == IW'(DEPTH - 1)) ? '0 : p_idx + 1'b1;

  // Evaluation of the slot read in the previous cycle.
  assign eval    = (state == S_PROBE) && q_vld;
  assign e_valid = mem_q[KEY_W];
  assign e_eq    = (mem_q[KEY_W-1:0] == key);

  always_comb begin
    e_res   = '{status: ST_OK, found: 1'b0, slot: SLOT_W'(q_idx)};
    e_stop  = 1'b0;
    wr_en   = 1'b0;
    wr_addr = q_idx;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = p_idx;
    end else if (eval) begin
      if (op == OP_OPEN) begin
        if (!e_valid) begin
          e_stop  = 1'b1;
          wr_en   = 1'b1;
          wr_data = {1'b1, key};
        end else if (e_eq) begin
          e_stop      = 1'b1;
          e_res.found = 1'b1;
        end
      end else if (e_valid && e_eq) begin
        e_stop      = 1'b1;
        e_res.found = 1'b1;
        wr_en       = (op == OP_CLOSE);
      end
    end
    e_miss = eval && !e_stop && (ev_cnt == IW'(DEPTH - 1));
    if (e_miss) begin
      e_res.slot = '0;
      case (op)
        OP_OPEN:   e_res.status = ST_FULL;
        OP_LOOKUP: e_res.status = ST_NOT_FOUND;
        default:   e_res.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[p_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      p_idx  <= '0;
      q_vld  <= 1'b0;
      ev_cnt <= '0;
      done   <= 1'b0;
    end else begin
      done  <= 1'b0;
      q_vld <= (state == S_PROBE);
      case (state)
        S_CLEAR: begin
          p_idx <= p_idx_next;
          if (p_idx == IW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (probe_op && !mismatch) begin
              state <= S_HASH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_HASH: begin
          if (hash_last) begin
            p_idx  <= hash_rem;
            ev_cnt <= '0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          p_idx <= p_idx_next;
          if (eval) begin
            ev_cnt <= ev_cnt + 1'b1;
          end
          if (e_stop || e_miss) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_idx <= p_idx;
    if (accept) begin
      key <= cmd_key;
      op  <= cmd.opcode;
      if (!probe_op) begin
        result <= '{status: ST_OK, found: 1'b0, slot: '0};
      end else begin
        result <= '{status: ST_MISMATCH, found: 1'b0, slot: '0};
      end
    end else if (e_stop || e_miss) begin
      result <= e_res;
    end
  end

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the table is still busy");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.status == ST_OK))
    else $error("found reported with a failing status");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

endmodule

[src/lppt_hash.sv]
module lppt_hash #(
  parameter int DEPTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [lppt_pkg::KEY_W-1:0]    key,
  output logic                          last,
  output logic [$clog2(DEPTH)-1:0]      rem
);
  import lppt_pkg::*;

  localparam int IW    = $clog2(DEPTH);
  localparam int RW    = IW + 1;
  localparam int STEPS = 8;
  localparam int NCYC  = KEY_W / STEPS;
  localparam int CW    = $clog2(NCYC);

  logic             active;
  logic [CW-1:0]    cnt;
  logic [KEY_W-1:0] shreg;
  logic [IW-1:0]    r;
  logic [RW-1:0]    acc;

  // Eight bits of the key a cycle, most significant first, one
  // shift-and-subtract step for each bit.
  always_comb begin
    acc = RW'(r);
    for (int i = 0; i < STEPS; i++) begin
      acc = {acc[RW-2:0], shreg[KEY_W-1-i]};
      if (acc >= RW'(DEPTH)) begin
        acc = acc - RW'(DEPTH);
      end
    end
  end

  assign rem  = acc[IW-1:0];
  assign last = active && (cnt == CW'(NCYC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (go) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= key;
      r     <= '0;
    end else if (active) begin
      shreg <= shreg << STEPS;
      r     <= rem;
    end
  end

endmodule
